>>> rtl/core/cpq_pkg.sv
// Shared types, constants and request codes for the chord pitch quantizer.
`default_nettype none
package cpq_pkg;
  localparam int MaxNotes  = 16;
  localparam int FracBits  = 16;
  localparam int AddrW     = $clog2(MaxNotes);
  localparam int SizeW     = $clog2(MaxNotes + 1);
  localparam int VoltW     = 21;
  localparam int OutW      = 22;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 8;
  localparam int WideW     = 26;

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_QUANT = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [CfgIdxW-1:0] CFG_MODE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TOL   = 2'd2;

  localparam logic [1:0] MODE_BELOW   = 2'd0;
  localparam logic [1:0] MODE_CL_DOWN = 2'd1;
  localparam logic [1:0] MODE_UP      = 2'd2;
  localparam logic [1:0] MODE_CL_UP   = 2'd3;
endpackage
`default_nettype wire

>>> rtl/core/cpq_if.sv
// Valid/ready channel interfaces for request and result beats.
`default_nettype none
interface cpq_in_if;
  import cpq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic signed [VoltW-1:0] voltage;
  modport source (output valid, req_type, voltage, input ready);
  modport sink   (input valid, req_type, voltage, output ready);
endinterface

interface cpq_out_if;
  import cpq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] quantized_voltage;
  modport source (output valid, quantized_voltage, input ready);
  modport sink   (input valid, quantized_voltage, output ready);
endinterface
`default_nettype wire

>>> rtl/core/chord_pitch_quantizer.sv
// Top level of the chord pitch quantizer: sequencer, note memory and output register.
`default_nettype none
// One request beat at a time. Begin and unknown requests are handled in idle. Add
// scans the sorted note memory from the top, one entry a cycle, shifting larger
// entries up to open a slot. Quantize reads the last list entry, then walks the
// list (ascending for down modes, descending for up modes) with the two wrapped
// pads one entry a cycle, then adds octave and shift (an empty chord counts as
// the single note C); the closest modes stop early once the distance grows. The
// single note memory port is why each scan takes one entry at a time. The output
// register frees the sequencer while a result waits, until the next result is
// due.
module chord_pitch_quantizer
  import cpq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  cpq_in_if.sink                   in_ch,
  cpq_out_if.source                out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_data
);
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ADDRD = 7'b0000010,
    ST_ADDWR = 7'b0000100,
    ST_QREAD = 7'b0001000,
    ST_QSCAN = 7'b0010000,
    ST_QSUM  = 7'b0100000,
    ST_QOUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [1:0]        mode_r;
  logic signed [3:0] shift_r;
  logic [7:0]        tol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CL_DOWN; shift_r <= '0; tol_r <= 8'd7;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MODE:  mode_r  <= cfg_data[1:0];
        CFG_SHIFT: shift_r <= cfg_data[3:0];
        CFG_TOL:   tol_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // note memory, one read-modify-write port
  logic [FracBits-1:0] mem [MaxNotes];
  logic [FracBits-1:0] rd_q;
  logic [AddrW-1:0]    rd_addr, wr_addr;
  logic [FracBits-1:0] wr_data;
  logic                wr_en;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  logic [SizeW-1:0]     size_r;
  logic [FracBits-1:0]  note_r;    // new note or quantize fraction
  logic signed [VoltW-1:0] base_r; // voltage minus fraction
  logic [SizeW-1:0]     k_r;       // scan position
  logic                 down_r;

  // list entries are held as signed 18 bit values (pads reach +-1 volt)
  localparam int LW = FracBits + 2;
  logic signed [LW-1:0] first_r, last_r, prev_r, pick_r, cur;
  logic signed [LW+1:0] diff_r;
  logic                 done_r;
  logic [SizeW:0]       idx_r;     // list index being judged, 0..n+1
  logic [SizeW:0]       n_r;

  logic                 ovalid_r;
  logic signed [OutW-1:0] oval_r;
  logic signed [WideW-1:0] sum_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.quantized_voltage = oval_r;

  wire acc = in_ch.valid && in_ch.ready;

  // memory address for the list entry at list index j (1..n)
  function automatic logic [AddrW-1:0] addr_of(input logic [SizeW:0] j,
      input logic [SizeW:0] n, input logic dn);
    logic [SizeW:0] a;
    a = dn ? (j - 1'b1) : (n - j);
    return a[AddrW-1:0];
  endfunction

  logic signed [LW-1:0] one_v;
  assign one_v = LW'(1) <<< FracBits;

  // next list index; the scan addresses it so its data lands on rd_q in time
  logic [SizeW:0] nxt_idx;
  always_comb nxt_idx = idx_r + 1'b1;

  // current list entry in scan: index idx_r, from memory or pad
  always_comb begin
    if (idx_r == '0) cur = down_r ? last_r - one_v : last_r + one_v;
    else if (idx_r == n_r + 1'b1) cur = down_r ? first_r + one_v : first_r - one_v;
    else if (size_r == '0) cur = '0;
    else cur = $signed({2'b00, rd_q});
  end

  logic signed [LW+1:0] t_cur, pdiff;
  logic signed [LW+1:0] tol_s;
  assign tol_s = $signed({{(LW-6){1'b0}}, tol_r});
  assign pdiff = (LW+2)'(cur) - (LW+2)'($signed({2'b00, note_r}));
  assign t_cur = pdiff < 0 ? -pdiff : pdiff;
  logic signed [LW+1:0] dd;
  assign dd = (t_cur - diff_r) < 0 ? diff_r - t_cur : t_cur - diff_r;

  always_comb begin
    state_nxt = state_r;
    rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = note_r;
    unique case (state_r)
      ST_IDLE: begin
        rd_addr = AddrW'(size_r - 1'b1);
        if (acc) begin
          unique case (in_ch.req_type)
            REQ_ADD:   state_nxt = (size_r >= SizeW'(MaxNotes)) ? ST_IDLE
                                   : (size_r == '0 ? ST_ADDWR : ST_ADDRD);
            REQ_QUANT: state_nxt = ST_QREAD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      // rd_q holds entry k_r-1; shift it up if greater than the note
      ST_ADDRD: begin
        if (rd_q > note_r) begin
          wr_en = 1'b1; wr_addr = AddrW'(k_r); wr_data = rd_q;
          if (k_r == SizeW'(1)) state_nxt = ST_ADDWR;
          rd_addr = AddrW'(k_r - 2'd2);
        end else begin
          state_nxt = ST_ADDWR;
        end
      end
      ST_ADDWR: begin
        wr_en = 1'b1; wr_addr = AddrW'(k_r);
        state_nxt = ST_IDLE;
      end
      // fetch the last list entry for the pad at list index 0
      ST_QREAD: begin
        if (k_r == '0) begin
          rd_addr = addr_of(n_r, n_r, down_r);
        end else begin
          state_nxt = ST_QSCAN;
        end
      end
      ST_QSCAN: begin
        rd_addr = addr_of(nxt_idx, n_r, down_r);
        if (done_r) state_nxt = ST_QSUM;
      end
      ST_QSUM: state_nxt = ST_QOUT;
      ST_QOUT: if (!ovalid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; size_r <= '0; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      if (state_r == ST_QOUT && state_nxt == ST_IDLE) ovalid_r <= 1'b1;
      if (acc && in_ch.req_type == REQ_BEGIN) size_r <= '0;
      if (state_r == ST_ADDWR) size_r <= size_r + 1'b1;
    end
  end

  // datapath
  logic signed [WideW-1:0] r_s;
  always_comb begin
    r_s = WideW'(base_r) + WideW'(pick_r)
        + (WideW'(shift_r) <<< FracBits);
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: if (acc) begin
        note_r <= in_ch.voltage[FracBits-1:0];
        base_r <= in_ch.voltage & ~VoltW'((1 << FracBits) - 1);
        k_r    <= in_ch.req_type == REQ_QUANT ? '0 : size_r;
        down_r <= (mode_r == MODE_BELOW) || (mode_r == MODE_CL_DOWN);
        n_r    <= size_r == '0 ? (SizeW+1)'(1) : (SizeW+1)'(size_r);
      end
      ST_ADDRD: if (rd_q > note_r) k_r <= k_r - 1'b1;
      ST_QREAD: begin
        k_r <= k_r + 1'b1;
        if (k_r == SizeW'(1))
          last_r <= size_r == '0 ? '0 : $signed({2'b00, rd_q});
        idx_r <= '0; done_r <= 1'b0; prev_r <= '0;
      end
      ST_QSCAN: begin
        if (idx_r == (SizeW+1)'(1))
          first_r <= cur;
        if (!done_r) begin
          prev_r <= cur;
          idx_r  <= nxt_idx;
          if (mode_r[0]) begin
            if (idx_r == '0) begin
              diff_r <= t_cur; pick_r <= cur;
            end else if ((dd < tol_s && cur != prev_r) || t_cur > diff_r) begin
              done_r <= 1'b1;
            end else begin
              diff_r <= t_cur; pick_r <= cur;
            end
          end else begin
            // keep last qualifying entry; a highest-first search picks the max index
            if (mode_r == MODE_UP ? (pdiff > tol_s) : (pdiff < tol_s))
              pick_r <= cur;
            else if (idx_r == '0) pick_r <= cur;
          end
          if (idx_r == n_r + 1'b1) done_r <= 1'b1;
        end
      end
      ST_QSUM: sum_r <= r_s;
      default: ;
    endcase
    if (state_r == ST_QOUT && state_nxt == ST_IDLE) begin
      if (sum_r > WideW'(20 * (1 << FracBits) - 1))
        oval_r <= OutW'(20 * (1 << FracBits) - 1);
      else if (sum_r < -WideW'(20 * (1 << FracBits)))
        oval_r <= -OutW'(20 * (1 << FracBits));
      else oval_r <= sum_r[OutW-1:0];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/cpq_checker.sv
// Port-level checker for the chord pitch quantizer, bound to the top level.
`default_nettype none
module cpq_checker
  import cpq_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [OutW-1:0] out_q
);
  // hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_q)) else $error("result dropped");
  // result stays in the volt range
  a_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_q) < $signed(OutW'(20 << FracBits))) &&
                  ($signed(out_q) >= -$signed(OutW'(20 << FracBits)))) else $error("range");
  // result beat carries known bits
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_q)) else $error("unknown result");
  // handshake outputs are known once out of reset
  a_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_ready, out_valid})) else $error("unknown handshake");
endmodule

bind chord_pitch_quantizer cpq_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_q(out_ch.quantized_voltage));
`default_nettype wire
